FILE: hdl/dvr_pkg.sv
package dvr_pkg;

  localparam int NODES = 8;
  localparam int IDX_W = $clog2(NODES);

  localparam logic [7:0] INF_COST = 8'd99;
  localparam logic [7:0] NO_HOP = 8'hFF;
  localparam logic [8:0] MAX_SUM = 9'd50;

  localparam logic [1:0] ACT_LINK = 2'd0;
  localparam logic [1:0] ACT_ROUTE = 2'd1;
  localparam logic [1:0] ACT_VECTOR = 2'd2;

  typedef struct packed {
    logic [7:0] via;
    logic [7:0] cost;
  } route_entry_t;

  localparam route_entry_t ROUTE_RESET = '{via: NO_HOP, cost: INF_COST};

  function automatic logic in_table(input logic [6:0] n);
    in_table = (n != 7'd0) && (n <= 7'(NODES));
  endfunction

endpackage

FILE: hdl/dvr_table.sv
module dvr_table #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter logic [WIDTH-1:0] RESET_VAL = '0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  // Entries not yet written read as the reset value.
  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= valid[raddr] ? mem[raddr] : RESET_VAL;
  end

endmodule

FILE: hdl/distance_vector_route_update.sv
// Channel  Dir  Signals                        Contents
// s        in   s_tvalid s_tready s_tdata      action, entry_index, cost_value,
//               s_tlast                        hop_value, sender; last_element
// m        out  m_tvalid m_tready m_tdata      table_changed, vector_aborted
// cfg      in   cfg_we cfg_wdata               own_id
//
// A vector element steps through ST_RD, ST_ADD, ST_UPD and ST_FIN, set by the
// single read port of the route table, which is read once for the sender and
// once for the destination. An element that is skipped goes straight to ST_FIN.
// Synchronous reset returns all tables to infinite cost with no hop.
// A result waiting on m stalls the block only when the next last element ends.
module distance_vector_route_update
  import dvr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // action[1:0], entry_index[8:2], cost_value[16:9], hop_value[24:17], sender[31:25]
  input  logic [31:0] s_tdata,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // table_changed[0], vector_aborted[1], zero[7:2]
  output logic [7:0]  m_tdata,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD = 3'd1;
  localparam logic [2:0] ST_ADD = 3'd2;
  localparam logic [2:0] ST_UPD = 3'd3;
  localparam logic [2:0] ST_FIN = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [6:0] own_id;
  logic [6:0] position;
  logic       cost_changed;
  logic       skipping_rest;

  logic [7:0] adv_cost;
  logic [6:0] sender;
  logic       last_element;
  logic [8:0] sum;

  logic       table_changed;
  logic       vector_aborted;

  logic [1:0]        in_action;
  logic [6:0]        in_index;
  logic [7:0]        in_cost;
  logic signed [7:0] in_hop;
  logic [6:0]        in_sender;
  logic              accept;

  logic [IDX_W-1:0] snd_idx;
  logic [IDX_W-1:0] pos_idx;
  logic [IDX_W-1:0] wr_idx;
  logic             snd_ok;

  logic             route_we;
  logic [IDX_W-1:0] route_waddr;
  route_entry_t     route_wdata;
  logic [IDX_W-1:0] route_raddr;
  route_entry_t     route_rdata;
  logic             link_we;
  logic [7:0]       link_rdata;

  logic [8:0]   sum_next;
  logic         zero_abort;
  logic         replace;
  route_entry_t new_entry;
  logic [6:0]   pos_minus;
  logic [6:0]   snd_minus;
  logic [6:0]   idx_minus;

  assign in_action = s_tdata[1:0];
  assign in_index = s_tdata[8:2];
  assign in_cost = s_tdata[16:9];
  assign in_hop = s_tdata[24:17];
  assign in_sender = s_tdata[31:25];

  assign s_tready = (state == ST_IDLE) && !rst;
  assign accept = s_tvalid && s_tready;

  assign pos_minus = position - 7'd1;
  assign snd_minus = sender - 7'd1;
  assign idx_minus = in_index - 7'd1;
  assign pos_idx = pos_minus[IDX_W-1:0];
  assign snd_idx = snd_minus[IDX_W-1:0];
  assign wr_idx = idx_minus[IDX_W-1:0];
  assign snd_ok = in_table(sender);

  assign m_tdata = {6'd0, vector_aborted, table_changed};

  always_comb begin
    sum_next = {1'b0, adv_cost};
    if (snd_ok && (route_rdata.cost != INF_COST)) begin
      sum_next = {1'b0, adv_cost} + {1'b0, link_rdata};
    end
  end

  always_comb begin
    zero_abort = (sum == 9'd0) && (position != own_id);
    replace = (sum < {1'b0, route_rdata.cost}) || (route_rdata.via == {1'b0, sender});
    if (sum > MAX_SUM) begin
      new_entry = ROUTE_RESET;
    end else begin
      new_entry = '{via: {1'b0, sender}, cost: sum[7:0]};
    end
  end

  always_comb begin
    route_we = 1'b0;
    route_waddr = wr_idx;
    route_wdata = '{via: in_hop, cost: in_cost};
    if (state == ST_UPD) begin
      route_we = !zero_abort && replace;
      route_waddr = pos_idx;
      route_wdata = new_entry;
    end else if (accept && (in_action == ACT_ROUTE) && in_table(in_index)) begin
      route_we = 1'b1;
    end
  end

  assign link_we = accept && (in_action == ACT_LINK) && in_table(in_index);
  assign route_raddr = (state == ST_ADD) ? pos_idx : snd_idx;

  dvr_table #(
    .WIDTH($bits(route_entry_t)),
    .DEPTH(NODES),
    .RESET_VAL(ROUTE_RESET)
  ) u_route (
    .clk   (clk),
    .rst   (rst),
    .we    (route_we),
    .waddr (route_waddr),
    .wdata (route_wdata),
    .raddr (route_raddr),
    .rdata (route_rdata)
  );

  dvr_table #(
    .WIDTH(8),
    .DEPTH(NODES),
    .RESET_VAL(INF_COST)
  ) u_link (
    .clk   (clk),
    .rst   (rst),
    .we    (link_we),
    .waddr (wr_idx),
    .wdata (in_cost),
    .raddr (snd_idx),
    .rdata (link_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (in_action == ACT_VECTOR)) begin
          if (skipping_rest || !in_table(position)) begin
            state_next = ST_FIN;
          end else begin
            state_next = ST_RD;
          end
        end
      end
      ST_RD: state_next = ST_ADD;
      ST_ADD: state_next = ST_UPD;
      ST_UPD: state_next = ST_FIN;
      ST_FIN: begin
        if (!last_element || !m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      own_id <= 7'd1;
      position <= 7'd1;
      cost_changed <= 1'b0;
      skipping_rest <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        own_id <= cfg_wdata;
      end
      if ((state == ST_FIN) && (state_next == ST_IDLE) && last_element) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == ST_UPD) begin
        if (zero_abort) begin
          skipping_rest <= 1'b1;
        end else if (replace && (new_entry.cost != route_rdata.cost)) begin
          cost_changed <= 1'b1;
        end
      end
      if ((state == ST_FIN) && (state_next == ST_IDLE)) begin
        if (last_element) begin
          position <= 7'd1;
          cost_changed <= 1'b0;
          skipping_rest <= 1'b0;
        end else if (position != 7'd127) begin
          position <= position + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      adv_cost <= in_cost;
      sender <= in_sender;
      last_element <= s_tlast;
    end
    if (state == ST_ADD) begin
      sum <= sum_next;
    end
    if ((state == ST_FIN) && (state_next == ST_IDLE) && last_element) begin
      table_changed <= !skipping_rest && cost_changed;
      vector_aborted <= skipping_rest;
    end
  end

endmodule
